/* rtl/sbcs_pkg.sv */
// ----------------------------------------------------------------------------
// sbcs_pkg: servo bus command scheduler shared definitions
// Codes, slot row layout, queue item and result types.
// ----------------------------------------------------------------------------
package sbcs_pkg;

  localparam int NUM_SLOTS   = 254;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int ID_W        = 8;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [ID_W-1:0] BROADCAST_ID   = 8'hFE;
  localparam logic [7:0]      RESEND_DEFAULT = 8'd10;

  // host opcodes
  localparam logic [2:0] OP_SET_MODE   = 3'd0;
  localparam logic [2:0] OP_SET_TARGET = 3'd1;
  localparam logic [2:0] OP_RELEASE    = 3'd2;
  localparam logic [2:0] OP_ENGAGE     = 3'd3;
  localparam logic [2:0] OP_SCAN       = 3'd4;
  localparam logic [2:0] OP_SHUTDOWN   = 3'd5;

  // bus commands
  localparam logic [2:0] CMD_HOLD = 3'd0;
  localparam logic [2:0] CMD_MODE = 3'd1;
  localparam logic [2:0] CMD_VEL  = 3'd2;
  localparam logic [2:0] CMD_POS  = 3'd3;
  localparam logic [2:0] CMD_OFF  = 3'd4;

  localparam logic [1:0] MODE_POSITION = 2'd0;
  localparam logic [1:0] MODE_VELOCITY = 2'd1;

  typedef enum logic [1:0] {
    SLOT_UNMANAGED = 2'd0,
    SLOT_ENABLING  = 2'd1,
    SLOT_ON        = 2'd2,
    SLOT_DISABLING = 2'd3
  } slot_state_t;

  typedef enum logic [2:0] {
    KIND_SET_MODE,
    KIND_SET_TARGET,
    KIND_RELEASE,
    KIND_ENGAGE,
    KIND_SCAN,
    KIND_SHUTDOWN
  } item_kind_t;

  typedef struct packed {
    slot_state_t        state;
    logic [1:0]         mode;
    logic signed [15:0] target;
    logic [7:0]         countdown;
  } slot_row_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [SLOT_W-1:0]  slot;
    logic [1:0]         mode;
    logic signed [15:0] target;
  } queue_item_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [ID_W-1:0]    id;
    logic signed [15:0] val;
    logic [1:0]         mode;
  } result_t;

endpackage

/* rtl/sbcs_ram.sv */
// ----------------------------------------------------------------------------
// sbcs_ram: generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module sbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/sbcs_queue.sv */
// ----------------------------------------------------------------------------
// sbcs_queue: small item queue between front and back
// Flop-based FIFO of classified items.
// ----------------------------------------------------------------------------
module sbcs_queue
  import sbcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  queue_item_t push_item,
  output logic        not_full,
  input  logic        pop,
  output logic        not_empty,
  output queue_item_t head
);

  queue_item_t       entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign not_full  = (count != QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_item;
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/sbcs_front.sv */
// ----------------------------------------------------------------------------
// sbcs_front: input acceptance and classification
// Maps opcodes to item kinds and drops items that have no effect.
// ----------------------------------------------------------------------------
module sbcs_front
  import sbcs_pkg::*;
(
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [2:0]         op,
  input  logic [ID_W-1:0]    servo_id,
  input  logic [1:0]         mode_in,
  input  logic signed [15:0] target_in,
  input  logic               q_not_full,
  output logic               q_push,
  output queue_item_t        q_item
);

  logic keep;
  logic id_ok;

  assign id_ok     = (servo_id < ID_W'(NUM_SLOTS));
  assign cmd_ready = q_not_full;
  assign q_push    = cmd_valid && cmd_ready && keep;

  always_comb begin
    q_item.slot   = servo_id[SLOT_W-1:0];
    q_item.mode   = mode_in;
    q_item.target = target_in;
    q_item.kind   = KIND_SCAN;
    keep          = 1'b0;
    unique case (op)
      OP_SET_MODE: begin
        q_item.kind = KIND_SET_MODE;
        keep        = id_ok;
      end
      OP_SET_TARGET: begin
        q_item.kind = KIND_SET_TARGET;
        keep        = id_ok;
      end
      OP_RELEASE: begin
        q_item.kind = KIND_RELEASE;
        keep        = id_ok;
      end
      OP_ENGAGE: begin
        q_item.kind = KIND_ENGAGE;
        keep        = id_ok;
      end
      OP_SCAN: begin
        q_item.kind = KIND_SCAN;
        keep        = 1'b1;
      end
      OP_SHUTDOWN: begin
        q_item.kind = KIND_SHUTDOWN;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/sbcs_back.sv */
// ----------------------------------------------------------------------------
// sbcs_back: slot table sequencer and result output register
// Executes queued items against the slot RAM, walks the scan, emits commands.
// ----------------------------------------------------------------------------
module sbcs_back
  import sbcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         resend_period,
  input  logic               q_not_empty,
  input  queue_item_t        q_head,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [2:0]         command,
  output logic [ID_W-1:0]    target_id,
  output logic signed [15:0] target_out,
  output logic [1:0]         mode_out,
  output logic               last
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EMIT} state_t;

  state_t            state;
  queue_item_t       cur;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] scan_pos;
  result_t           res0;
  result_t           res1;
  logic              two;
  logic              sel;
  logic              written [NUM_SLOTS];
  logic              written_q;

  logic                        ram_we;
  logic [SLOT_W-1:0]           ram_addr;
  slot_row_t                   ram_wdata;
  logic [$bits(slot_row_t)-1:0] ram_rdata;

  slot_row_t         row_cur;
  slot_row_t         row_upd;
  logic [SLOT_W-1:0] idx_inc;
  logic              idx_last;
  logic              is_scan;
  logic              slot_free;
  logic [7:0]        cd_base;
  logic [7:0]        cd_dec;
  result_t           ra;
  result_t           rb;
  logic [1:0]        n_res;
  logic              out_free;
  logic              emit_load;

  sbcs_ram #(
    .WIDTH ($bits(slot_row_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // never-written rows read as the reset row
  assign row_cur   = written_q ? slot_row_t'(ram_rdata) : '0;
  assign idx_inc   = idx + 1'b1;
  assign idx_last  = (idx == SLOT_W'(NUM_SLOTS - 1));
  assign is_scan   = (cur.kind == KIND_SCAN);
  assign slot_free = (row_cur.state == SLOT_UNMANAGED);
  assign out_free  = !res_valid || res_ready;
  assign emit_load = (state == S_EMIT) && out_free;
  assign q_pop     = (state == S_IDLE) && q_not_empty;

  // countdown: enabling reloads with the period before the decrement
  assign cd_base = (row_cur.state == SLOT_ENABLING) ? resend_period : row_cur.countdown;
  assign cd_dec  = cd_base - 8'd1;

  // row update
  always_comb begin
    row_upd = row_cur;
    case (cur.kind)
      KIND_SET_MODE: begin
        row_upd.state = SLOT_ENABLING;
        row_upd.mode  = cur.mode;
      end
      KIND_SET_TARGET: row_upd.target = cur.target;
      KIND_RELEASE:    row_upd.state  = SLOT_DISABLING;
      KIND_ENGAGE:     row_upd.state  = SLOT_ENABLING;
      default: begin
        if (row_cur.state == SLOT_ENABLING || row_cur.state == SLOT_ON) begin
          row_upd.state     = SLOT_ON;
          row_upd.countdown = (cd_dec == 8'd0) ? resend_period : cd_dec;
        end else if (row_cur.state == SLOT_DISABLING) begin
          row_upd.state = SLOT_UNMANAGED;
        end
      end
    endcase
  end

  // commands for a visited slot
  always_comb begin
    result_t r_mode;
    result_t r_tgt;
    logic    has_tgt;
    r_mode  = '{cmd: CMD_MODE, id: ID_W'(idx), val: '0, mode: row_cur.mode};
    r_tgt   = '{cmd: (row_cur.mode == MODE_VELOCITY) ? CMD_VEL : CMD_POS,
                id: ID_W'(idx), val: row_cur.target, mode: '0};
    has_tgt = (row_cur.mode == MODE_VELOCITY) || (row_cur.mode == MODE_POSITION);
    ra      = r_mode;
    rb      = r_tgt;
    n_res   = 2'd0;
    case (row_cur.state)
      SLOT_ENABLING: begin
        if (row_cur.mode == MODE_POSITION) begin
          ra    = '{cmd: CMD_HOLD, id: ID_W'(idx), val: '0, mode: '0};
          rb    = r_mode;
          n_res = 2'd2;
        end else begin
          n_res = 2'd1;
        end
      end
      SLOT_DISABLING: begin
        ra    = '{cmd: CMD_OFF, id: ID_W'(idx), val: '0, mode: '0};
        n_res = 2'd1;
      end
      SLOT_ON: begin
        if (row_cur.countdown == 8'd1) begin
          n_res = has_tgt ? 2'd2 : 2'd1;
        end else if (has_tgt) begin
          ra    = r_tgt;
          n_res = 2'd1;
        end
      end
      default: n_res = 2'd0;
    endcase
  end

  // RAM port: read in idle and while skipping, write when the slot is done
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx;
    ram_wdata = row_upd;
    unique case (state)
      S_IDLE: ram_addr = (q_head.kind == KIND_SCAN) ? scan_pos : q_head.slot;
      S_LOOK: begin
        if (!is_scan || !slot_free) begin
          ram_we = 1'b1;
        end else if (!idx_last) begin
          ram_addr = idx_inc;
        end
      end
      default: ram_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    written_q <= written[ram_addr];
    if (rst) begin
      state     <= S_IDLE;
      scan_pos  <= '0;
      res_valid <= 1'b0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        written[k] <= 1'b0;
      end
    end else begin
      if (ram_we) begin
        written[ram_addr] <= 1'b1;
      end
      if (out_free) begin
        res_valid <= emit_load;
      end
      if (emit_load) begin
        command    <= sel ? res1.cmd  : res0.cmd;
        target_id  <= sel ? res1.id   : res0.id;
        target_out <= sel ? res1.val  : res0.val;
        mode_out   <= sel ? res1.mode : res0.mode;
        last       <= sel || !two;
      end
      unique case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            cur <= q_head;
            if (q_head.kind == KIND_SHUTDOWN) begin
              res0  <= '{cmd: CMD_OFF, id: BROADCAST_ID, val: '0, mode: '0};
              two   <= 1'b0;
              sel   <= 1'b0;
              state <= S_EMIT;
            end else begin
              idx   <= ram_addr;
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (!is_scan) begin
            state <= S_IDLE;
          end else if (slot_free) begin
            if (idx_last) begin
              scan_pos <= '0;
              state    <= S_IDLE;
            end else begin
              idx <= idx_inc;
            end
          end else begin
            scan_pos <= idx_last ? '0 : idx_inc;
            res0     <= ra;
            res1     <= rb;
            two      <= (n_res == 2'd2);
            sel      <= 1'b0;
            state    <= (n_res == 2'd0) ? S_IDLE : S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (two && !sel) begin
              sel <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> (idx < SLOT_W'(NUM_SLOTS)))
    else $error("slot index out of range during lookup");

  a_second_only_when_two: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && sel) |-> two)
    else $error("second result selected for a single-result item");

  a_not_last_keeps_emitting: assert property (@(posedge clk) disable iff (rst)
    (emit_load && two && !sel) |=> (state == S_EMIT && sel))
    else $error("first of two results loaded but second not pending");

endmodule

/* rtl/servo_bus_command_scheduler.sv */
// ----------------------------------------------------------------------------
// servo_bus_command_scheduler: per-servo command scheduler for a serial bus
// Host items edit per-slot lifecycle, mode and target; scan items emit the
// bus commands for the next managed slot; shutdown emits a broadcast off.
//
// Channels: cmd (op, servo_id, mode_in, target_in) in, res (command,
// target_id, target_out, mode_out, last) out, both valid/ready. cfg writes
// resend_period (reset 10) and is always ready; write it only while idle.
// Items that cause nothing (unknown op, servo_id out of range) are taken and
// dropped at the front. The others enter a two-deep queue, so cmd_ready only
// drops while the queue is full.
// Back-end sequence: a host edit is a slot RAM read, then a write. A scan
// reads slots from the scan position on, skipping unmanaged ones (the single
// slot RAM port is read once per cycle), then emits its commands (up to two)
// as res_ready allows. Shutdown goes straight to emitting its broadcast off.
// last marks the final command of an item. If res_ready stays low the result
// register holds and the back end waits; the front keeps filling the queue.
// Reset: all slots unmanaged, scan starts at slot 0; per-row written bits
// make untouched rows read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module servo_bus_command_scheduler
  import sbcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  // item input
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [2:0]         op,
  input  logic [ID_W-1:0]    servo_id,
  input  logic [1:0]         mode_in,
  input  logic signed [15:0] target_in,
  // result output
  output logic               res_valid,
  input  logic               res_ready,
  output logic [2:0]         command,
  output logic [ID_W-1:0]    target_id,
  output logic signed [15:0] target_out,
  output logic [1:0]         mode_out,
  output logic               last
);

  logic [7:0]  resend_period;
  logic        q_push;
  logic        q_not_full;
  logic        q_not_empty;
  logic        q_pop;
  queue_item_t q_in;
  queue_item_t q_head;

  // one cfg reg, always ready, unchecked; host must write it only while idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      resend_period <= RESEND_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      resend_period <= cfg_data;
    end
  end

  // front: classify and filter
  sbcs_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .op         (op),
    .servo_id   (servo_id),
    .mode_in    (mode_in),
    .target_in  (target_in),
    .q_not_full (q_not_full),
    .q_push     (q_push),
    .q_item     (q_in)
  );

  // decoupling queue
  sbcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: slot table, scan walk, result register
  sbcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .resend_period (resend_period),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .command       (command),
    .target_id     (target_id),
    .target_out    (target_out),
    .mode_out      (mode_out),
    .last          (last)
  );

endmodule

/* sim/sbcs_checker.sv */
// ----------------------------------------------------------------------------
// sbcs_checker: result checker for the servo bus command scheduler
// Watches the cfg, cmd and res channels, keeps its own copy of the slot table,
// works out the bus commands each accepted item must cause and compares every
// accepted result with the oldest one still due.
// ----------------------------------------------------------------------------
module sbcs_checker
  import sbcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               cmd_valid,
  input  logic               cmd_ready,
  input  logic [2:0]         op,
  input  logic [ID_W-1:0]    servo_id,
  input  logic [1:0]         mode_in,
  input  logic signed [15:0] target_in,
  input  logic               res_valid,
  input  logic               res_ready,
  input  logic [2:0]         command,
  input  logic [ID_W-1:0]    target_id,
  input  logic signed [15:0] target_out,
  input  logic [1:0]         mode_out,
  input  logic               last,
  output int                 fail_count,
  output int                 commands_pending,
  output int                 items_taken,
  output int                 commands_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [ID_W-1:0]    id;
    logic signed [15:0] val;
    logic [1:0]         mode;
    logic               last;
  } bus_cmd_t;

  // slot table copy
  slot_state_t        slot_st [NUM_SLOTS];
  logic [1:0]         slot_md [NUM_SLOTS];
  logic signed [15:0] slot_tg [NUM_SLOTS];
  logic [7:0]         slot_cd [NUM_SLOTS];
  int                 scan_at;
  logic [7:0]         period;

  bus_cmd_t commands_due[$];
  bus_cmd_t item_cmds[2];
  int       item_ncmds;

  function void clear_slots();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_st[i] = SLOT_UNMANAGED;
      slot_md[i] = '0;
      slot_tg[i] = '0;
      slot_cd[i] = '0;
    end
    scan_at = 0;
    period  = RESEND_DEFAULT;
  endfunction

  function void add_command(logic [2:0] c, logic [ID_W-1:0] sid,
                            logic signed [15:0] v, logic [1:0] m);
    item_cmds[item_ncmds] = '{c, sid, v, m, 1'b0};
    item_ncmds++;
  endfunction

  task automatic scan_next_slot();
    int          i;
    slot_state_t st;
    logic [1:0]  md;
    logic [7:0]  cd;
    i = scan_at;
    while (i < NUM_SLOTS && slot_st[i] == SLOT_UNMANAGED)
      i++;
    // empty tail: pass ends quietly and wraps
    if (i >= NUM_SLOTS) begin
      scan_at = 0;
      return;
    end
    st = slot_st[i];
    md = slot_md[i];
    cd = slot_cd[i];
    case (st)
      SLOT_ENABLING: begin
        slot_st[i] = SLOT_ON;
        slot_cd[i] = period - 8'd1;
        if (slot_cd[i] == 8'd0)
          slot_cd[i] = period;
        if (md == MODE_POSITION)
          add_command(CMD_HOLD, 8'(i), '0, '0);
        add_command(CMD_MODE, 8'(i), '0, md);
      end
      SLOT_DISABLING: begin
        slot_st[i] = SLOT_UNMANAGED;
        add_command(CMD_OFF, 8'(i), '0, '0);
      end
      SLOT_ON: begin
        slot_cd[i] = cd - 8'd1;
        if (slot_cd[i] == 8'd0)
          slot_cd[i] = period;
        if (cd == 8'd1)
          add_command(CMD_MODE, 8'(i), '0, md);
        if (md == MODE_VELOCITY)
          add_command(CMD_VEL, 8'(i), slot_tg[i], '0);
        else if (md == MODE_POSITION)
          add_command(CMD_POS, 8'(i), slot_tg[i], '0);
      end
      default: ;
    endcase
    scan_at = (i + 1 >= NUM_SLOTS) ? 0 : i + 1;
  endtask

  task automatic take_item(logic [2:0] o, logic [ID_W-1:0] sid, logic [1:0] m,
                           logic signed [15:0] t);
    item_ncmds = 0;
    if (o <= OP_ENGAGE) begin
      if (sid < NUM_SLOTS) begin
        case (o)
          OP_SET_MODE: begin
            slot_st[sid] = SLOT_ENABLING;
            slot_md[sid] = m;
          end
          OP_SET_TARGET: slot_tg[sid] = t;
          OP_RELEASE:    slot_st[sid] = SLOT_DISABLING;
          default:       slot_st[sid] = SLOT_ENABLING;
        endcase
      end
    end else if (o == OP_SCAN) begin
      scan_next_slot();
    end else if (o == OP_SHUTDOWN) begin
      add_command(CMD_OFF, BROADCAST_ID, '0, '0);
    end
    for (int k = 0; k < item_ncmds; k++) begin
      item_cmds[k].last = (k == item_ncmds - 1);
      commands_due.push_back(item_cmds[k]);
    end
  endtask

  function void report(string what, bus_cmd_t want, bus_cmd_t got);
    if (fail_count < 10)
      $display("%0t %s: want cmd %0d id %0d val %0d mode %0d last %0b | got cmd %0d id %0d val %0d mode %0d last %0b",
               $realtime, what, want.cmd, want.id, want.val, want.mode, want.last,
               got.cmd, got.id, got.val, got.mode, got.last);
    fail_count++;
  endfunction

  always @(posedge clk) begin : monitor
    bus_cmd_t got;
    bus_cmd_t want;
    if (rst) begin
      clear_slots();
      commands_due.delete();
    end else begin
      if (res_valid && res_ready) begin
        got = '{command, target_id, target_out, mode_out, last};
        commands_checked++;
        if (commands_due.size() == 0) begin
          report("result with none due", '0, got);
        end else begin
          want = commands_due.pop_front();
          if (got !== want)
            report("result mismatch", want, got);
        end
      end
      if (cfg_valid && cfg_ready)
        period = cfg_data;
      if (cmd_valid && cmd_ready) begin
        items_taken++;
        take_item(op, servo_id, mode_in, target_in);
      end
    end
    commands_pending = commands_due.size();
  end

endmodule

/* sim/tb_servo_bus_command_scheduler.sv */
// ----------------------------------------------------------------------------
// tb_servo_bus_command_scheduler: testbench top for the command scheduler
// Drives a directed opener and then random host, scan and shutdown items
// through four flow-control phases, each with its own resend period; the
// checker beside the block predicts and compares every bus command.
// ----------------------------------------------------------------------------
module tb_servo_bus_command_scheduler;
  import sbcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // ops the block does not know; taken and dropped
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // quiet time before a cfg write and at the end: a scan may walk all slots
  // once per cycle, and up to two items sit in the queue
  localparam int SETTLE_CYCLES = 1000;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data  = '0;
  logic               cmd_valid = 1'b0;
  logic               cmd_ready;
  logic [2:0]         op        = '0;
  logic [ID_W-1:0]    servo_id  = '0;
  logic [1:0]         mode_in   = '0;
  logic signed [15:0] target_in = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic [2:0]         command;
  logic [ID_W-1:0]    target_id;
  logic signed [15:0] target_out;
  logic [1:0]         mode_out;
  logic               last;

  int fail_count;
  int commands_pending;
  int items_taken;
  int commands_checked;

  // percent of cycles the sender sits idle / the receiver holds ready low
  int idle_pct  = 0;
  int stall_pct = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  servo_bus_command_scheduler i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .op         (op),
    .servo_id   (servo_id),
    .mode_in    (mode_in),
    .target_in  (target_in),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .command    (command),
    .target_id  (target_id),
    .target_out (target_out),
    .mode_out   (mode_out),
    .last       (last)
  );

  sbcs_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .op               (op),
    .servo_id         (servo_id),
    .mode_in          (mode_in),
    .target_in        (target_in),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .command          (command),
    .target_id        (target_id),
    .target_out       (target_out),
    .mode_out         (mode_out),
    .last             (last),
    .fail_count       (fail_count),
    .commands_pending (commands_pending),
    .items_taken      (items_taken),
    .commands_checked (commands_checked)
  );

  // receiver: a fresh ready draw every cycle, one assignment per falling edge
  always @(negedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // One item on the cmd channel. Valid goes low only during idle cycles, so
  // back-to-back items keep it high; the handshake is sampled at the rising
  // edge, where the checker sees it too.
  task automatic send_item(logic [2:0] o, logic [ID_W-1:0] sid, logic [1:0] m,
                           logic signed [15:0] t);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    op        <= o;
    servo_id  <= sid;
    mode_in   <= m;
    target_in <= t;
    do @(posedge clk); while (!cmd_ready);
  endtask

  // Stop sending and wait until every due command has come back, then let
  // the back end finish any item that causes nothing.
  task automatic drain(int extra);
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (commands_pending != 0)
      @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // resend_period write; only called with the block idle
  task automatic write_period(logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random mix. Most addressed slots come from a small low pool so scans keep
  // landing on managed slots; a few go near the top of the table or out of
  // range. Only items the block acts on count toward n. Halfway through, the
  // sender holds off until everything due has arrived.
  task automatic run_random(int n);
    int              counted;
    int              r;
    bit              paused;
    logic [2:0]      o;
    logic [ID_W-1:0] sid;
    counted = 0;
    paused  = 1'b0;
    while (counted < n) begin
      r = $urandom_range(0, 99);
      if (r < 14)      o = OP_SET_MODE;
      else if (r < 30) o = OP_SET_TARGET;
      else if (r < 37) o = OP_RELEASE;
      else if (r < 44) o = OP_ENGAGE;
      else if (r < 86) o = OP_SCAN;
      else if (r < 90) o = OP_SHUTDOWN;
      else             o = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
      case ($urandom_range(0, 9))
        0:       sid = 8'($urandom_range(0, 255));
        1:       sid = 8'($urandom_range(NUM_SLOTS - 6, 255));
        default: sid = 8'($urandom_range(0, 11));
      endcase
      send_item(o, sid, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
      if (o == OP_SCAN || o == OP_SHUTDOWN || (o <= OP_ENGAGE && sid < NUM_SLOTS))
        counted++;
      if (!paused && counted >= n / 2) begin
        drain(0);
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // short period so the mode re-send shows up in the opener
    write_period(8'd2);

    // shutdown broadcast, then a scan over an empty table (no result)
    send_item(OP_SHUTDOWN, 8'd0, 2'd0, 16'sd0);
    send_item(OP_SCAN, 8'd0, 2'd0, 16'sd0);
    // lowest and highest slots, position / velocity / other modes,
    // target extremes
    send_item(OP_SET_MODE, 8'd0, MODE_POSITION, 16'sd0);
    send_item(OP_SET_TARGET, 8'd0, 2'd0, -16'sd32768);
    send_item(OP_SET_MODE, 8'(NUM_SLOTS - 1), MODE_VELOCITY, 16'sd0);
    send_item(OP_SET_TARGET, 8'(NUM_SLOTS - 1), 2'd3, 16'sd32767);
    send_item(OP_SET_MODE, 8'd5, 2'd2, 16'sd0);
    send_item(OP_SET_MODE, 8'd6, 2'd3, 16'sd0);
    // out-of-range slots and unknown ops are dropped
    send_item(OP_SET_MODE, BROADCAST_ID, MODE_VELOCITY, 16'sd0);
    send_item(OP_SET_TARGET, 8'd255, 2'd0, -16'sd1);
    send_item(OP_SPARE_LO, 8'd0, 2'd0, 16'sd0);
    send_item(OP_SPARE_HI, 8'd255, 2'd3, -16'sd1);
    // enable visits (hold + mode for position), then the on-state visits
    // with a wrap of the scan pointer past the top slot
    repeat (7) send_item(OP_SCAN, 8'd0, 2'd0, 16'sd0);
    // release a running slot and an unmanaged one, re-engage a running one
    send_item(OP_RELEASE, 8'd5, 2'd0, 16'sd0);
    send_item(OP_RELEASE, 8'd100, 2'd0, 16'sd0);
    send_item(OP_ENGAGE, 8'd0, 2'd0, 16'sd0);
    repeat (5) send_item(OP_SCAN, 8'd0, 2'd0, 16'sd0);
    send_item(OP_SHUTDOWN, 8'd0, 2'd0, 16'sd0);
    drain(SETTLE_CYCLES);

    // no idling, period at its low end
    write_period(8'd1);
    run_random(200);
    drain(SETTLE_CYCLES);

    // sender mostly idle, longest period
    idle_pct = 82;
    write_period(8'd255);
    run_random(200);
    drain(SETTLE_CYCLES);

    // receiver mostly stalled, zero period (countdown wraps to 255)
    idle_pct  = 0;
    stall_pct = 82;
    write_period(8'd0);
    run_random(200);
    drain(SETTLE_CYCLES);

    // light idling on both sides
    idle_pct  = 13;
    stall_pct = 13;
    write_period(8'd6);
    run_random(200);
    drain(SETTLE_CYCLES);

    $display("Covered %0d accepted items and %0d checked bus commands,",
             items_taken, commands_checked);
    $display("across four flow-control phases and resend periods 0, 1, 2, 6, 255.");
    if (fail_count == 0 && commands_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #12ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
rtl/sbcs_pkg.sv
rtl/sbcs_ram.sv
rtl/sbcs_queue.sv
rtl/sbcs_front.sv
rtl/sbcs_back.sv
rtl/servo_bus_command_scheduler.sv
sim/sbcs_checker.sv
sim/tb_servo_bus_command_scheduler.sv
